[design/ipc_pkg.sv]
`default_nettype none

package ipc_pkg;

    // Default build widths
    localparam int TIME_BITS_DEF   = 32;
    localparam int SENSOR_BITS_DEF = 10;

    // Fixed field widths
    localparam int TEMP_W       = 11;
    localparam int PCT_W        = 7;
    localparam int MODE_W       = 2;
    localparam int EV_W         = 3;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 32;
    localparam int SENSOR_CFG_W = 10;
    localparam int MAX_PUMP_W   = 16;
    localparam int LONG_MS_W    = 24;

    // Full scale of the moisture map
    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    // Register reset values
    localparam logic [PCT_W-1:0]        DRY_TH_RST    = 7'd30;
    localparam logic [PCT_W-1:0]        SAT_TH_RST    = 7'd45;
    localparam logic [MAX_PUMP_W-1:0]   MAX_PUMP_RST  = 16'd500;
    localparam logic [LONG_MS_W-1:0]    MIN_GAP_RST   = 24'd10000;
    localparam logic [LONG_MS_W-1:0]    SOAK_RST      = 24'd15000;
    localparam logic [TEMP_W-1:0]       TEMP_LIM_RST  = 11'd300;
    localparam logic [SENSOR_CFG_W-1:0] SENS_DRY_RST  = 10'd1023;
    localparam logic [SENSOR_CFG_W-1:0] SENS_WET_RST  = 10'd300;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DRY_TH   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_TH   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PUMP = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP  = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SOAK     = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIM = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_DRY = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_WET = 8'd7;

    // Pump modes
    localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WATER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SOAK  = 2'd2;

    // Event codes
    localparam logic [EV_W-1:0] EV_NONE  = 3'd0;
    localparam logic [EV_W-1:0] EV_START = 3'd1;
    localparam logic [EV_W-1:0] EV_HEAT  = 3'd2;
    localparam logic [EV_W-1:0] EV_STOP  = 3'd3;
    localparam logic [EV_W-1:0] EV_SOAK  = 3'd4;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic load;
        logic prep;
        logic step;
        logic eval;
    } ipc_cmd_t;

endpackage

`default_nettype wire

[design/ipc_sample_if.sv]
`default_nettype none

interface ipc_sample_if #(
    parameter int TIME_BITS   = ipc_pkg::TIME_BITS_DEF,
    parameter int SENSOR_BITS = ipc_pkg::SENSOR_BITS_DEF
);
    import ipc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [SENSOR_BITS-1:0]  raw_moisture;
    logic signed [TEMP_W-1:0] temperature_tenths;
    logic                    temp_valid;
    logic [TIME_BITS-1:0]    now_ms;

    modport source (output valid, raw_moisture, temperature_tenths, temp_valid, now_ms,
                    input ready);
    modport sink   (input valid, raw_moisture, temperature_tenths, temp_valid, now_ms,
                    output ready);
endinterface

`default_nettype wire

[design/ipc_result_if.sv]
`default_nettype none

interface ipc_result_if;
    import ipc_pkg::*;

    logic              valid;
    logic              ready;
    logic [PCT_W-1:0]  moisture_percent;
    logic              temp_high;
    logic              wants_water;
    logic              pump_on;
    logic [MODE_W-1:0] mode;
    logic [EV_W-1:0]   event_res;

    modport source (output valid, moisture_percent, temp_high, wants_water, pump_on, mode,
                    event_res, input ready);
    modport sink   (input valid, moisture_percent, temp_high, wants_water, pump_on, mode,
                    event_res, output ready);
endinterface

`default_nettype wire

[design/ipc_cfg_if.sv]
`default_nettype none

interface ipc_cfg_if;
    import ipc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/ipc_ctrl.sv]
`default_nettype none

module ipc_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output ipc_pkg::ipc_cmd_t     cmd
);
    import ipc_pkg::*;

    localparam int CNT_W = $clog2(PCT_W);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PCT_W - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_EVAL = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    // Result slot can take a new beat when empty or draining this cycle
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Sequence one sample: capture, prepare, divide, evaluate
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (out_free)
                begin
                    cmd.eval       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[design/ipc_datapath.sv]
`default_nettype none

module ipc_datapath #(
    parameter int TIME_BITS   = ipc_pkg::TIME_BITS_DEF,
    parameter int SENSOR_BITS = ipc_pkg::SENSOR_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire ipc_pkg::ipc_cmd_t               cmd,
    input  wire logic                            cfg_write,
    input  wire logic [ipc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ipc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [SENSOR_BITS-1:0]          raw_moisture,
    input  wire logic signed [ipc_pkg::TEMP_W-1:0] temperature_tenths,
    input  wire logic                            temp_valid,
    input  wire logic [TIME_BITS-1:0]            now_ms,
    output logic [ipc_pkg::PCT_W-1:0]            moisture_percent,
    output logic                                 temp_high,
    output logic                                 wants_water,
    output logic                                 pump_on,
    output logic [ipc_pkg::MODE_W-1:0]           mode,
    output logic [ipc_pkg::EV_W-1:0]             event_res
);
    import ipc_pkg::*;

    localparam int DIFF_W = SENSOR_BITS + 1;
    localparam int REM_W  = SENSOR_BITS + PCT_W;
    localparam int CMP_W  = (TIME_BITS > LONG_MS_W) ? TIME_BITS : LONG_MS_W;

    // Configuration registers
    logic [PCT_W-1:0]         dry_th_reg, sat_th_reg;
    logic [MAX_PUMP_W-1:0]    max_pump_reg;
    logic [LONG_MS_W-1:0]     min_gap_reg, soak_ms_reg;
    logic signed [TEMP_W-1:0] temp_lim_reg;
    logic [SENSOR_CFG_W-1:0]  sens_dry_reg, sens_wet_reg;

    // Captured sample
    logic [SENSOR_BITS-1:0]   raw_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic                     tvalid_reg;
    logic [TIME_BITS-1:0]     now_reg;

    // Divider and prepared flags
    logic [REM_W-1:0] rem_reg, dsh_reg;
    logic [PCT_W-1:0] quo_reg;
    logic             zero_out_reg, sat_reg, time_ge_reg;

    // Controller state
    logic                 pump_reg, pump_next;
    logic                 want_reg, want_next;
    logic                 soak_reg, soak_next;
    logic [TIME_BITS-1:0] last_water_reg, last_water_next;
    logic [TIME_BITS-1:0] pump_start_reg, pump_start_next;
    logic [TIME_BITS-1:0] soak_start_reg, soak_start_next;

    // Result register
    logic [PCT_W-1:0]  pct_out_reg;
    logic              hot_out_reg;
    logic [MODE_W-1:0] mode_next, mode_out_reg;
    logic [EV_W-1:0]   ev_next, ev_out_reg;

    // Prepare-stage signals
    logic [SENSOR_BITS-1:0]   dry_s, wet_s, mag_x, mag_d;
    logic [DIFF_W-1:0]        diff_x, diff_d;
    logic [TIME_BITS-1:0]     then_sel, elapsed;
    logic [LONG_MS_W-1:0]     limit_sel;

    // Evaluate-stage signals
    logic [PCT_W-1:0] pct;
    logic             hot, want_pre, is_dry, is_sat;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dry_th_reg   <= DRY_TH_RST;
            sat_th_reg   <= SAT_TH_RST;
            max_pump_reg <= MAX_PUMP_RST;
            min_gap_reg  <= MIN_GAP_RST;
            soak_ms_reg  <= SOAK_RST;
            temp_lim_reg <= TEMP_LIM_RST;
            sens_dry_reg <= SENS_DRY_RST;
            sens_wet_reg <= SENS_WET_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DRY_TH:   dry_th_reg   <= cfg_data[PCT_W-1:0];
                REG_SAT_TH:   sat_th_reg   <= cfg_data[PCT_W-1:0];
                REG_MAX_PUMP: max_pump_reg <= cfg_data[MAX_PUMP_W-1:0];
                REG_MIN_GAP:  min_gap_reg  <= cfg_data[LONG_MS_W-1:0];
                REG_SOAK:     soak_ms_reg  <= cfg_data[LONG_MS_W-1:0];
                REG_TEMP_LIM: temp_lim_reg <= cfg_data[TEMP_W-1:0];
                REG_SENS_DRY: sens_dry_reg <= cfg_data[SENSOR_CFG_W-1:0];
                REG_SENS_WET: sens_wet_reg <= cfg_data[SENSOR_CFG_W-1:0];
                default:      ;
            endcase
        end
    end

    // Capture the sample beat
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            raw_reg    <= raw_moisture;
            temp_reg   <= temperature_tenths;
            tvalid_reg <= temp_valid;
            now_reg    <= now_ms;
        end
    end

    // Signed offsets from the dry point, as sign and magnitude
    assign dry_s  = SENSOR_BITS'(sens_dry_reg);
    assign wet_s  = SENSOR_BITS'(sens_wet_reg);
    assign diff_x = {1'b0, raw_reg} - {1'b0, dry_s};
    assign diff_d = {1'b0, wet_s} - {1'b0, dry_s};
    assign mag_x  = diff_x[DIFF_W-1] ? SENSOR_BITS'(-diff_x) : diff_x[SENSOR_BITS-1:0];
    assign mag_d  = diff_d[DIFF_W-1] ? SENSOR_BITS'(-diff_d) : diff_d[SENSOR_BITS-1:0];

    // Pick the running timer by the current mode
    always_comb
    begin
        if (soak_reg)
        begin
            then_sel  = soak_start_reg;
            limit_sel = soak_ms_reg;
        end
        else if (pump_reg)
        begin
            then_sel  = pump_start_reg;
            limit_sel = LONG_MS_W'(max_pump_reg);
        end
        else
        begin
            then_sel  = last_water_reg;
            limit_sel = min_gap_reg;
        end
    end

    assign elapsed = now_reg - then_sel;

    // Prepare flags, then divide one quotient bit per step
    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            zero_out_reg <= (diff_d == '0) || (diff_x == '0) ||
                            (diff_x[DIFF_W-1] != diff_d[DIFF_W-1]);
            sat_reg      <= (mag_x >= mag_d);
            time_ge_reg  <= (CMP_W'(elapsed) >= CMP_W'(limit_sel));
            rem_reg      <= REM_W'(mag_x) * REM_W'(PCT_FULL);
            dsh_reg      <= REM_W'(mag_d) << (PCT_W - 1);
            quo_reg      <= '0;
        end
        else if (cmd.step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                quo_reg <= {quo_reg[PCT_W-2:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[PCT_W-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // Clamp: zero span or opposite signs give zero; past the span, full scale
    assign pct    = zero_out_reg ? '0 : (sat_reg ? PCT_FULL : quo_reg);
    assign hot    = tvalid_reg && (temp_reg > temp_lim_reg);
    assign is_dry = (pct <= dry_th_reg);
    assign is_sat = (pct >= sat_th_reg);

    always_comb
    begin
        if (is_dry)
        begin
            want_pre = 1'b1;
        end
        else if (is_sat)
        begin
            want_pre = 1'b0;
        end
        else
        begin
            want_pre = want_reg;
        end
    end

    // Advance the pump state machine
    always_comb
    begin
        pump_next       = pump_reg;
        want_next       = want_pre;
        soak_next       = soak_reg;
        last_water_next = last_water_reg;
        pump_start_next = pump_start_reg;
        soak_start_next = soak_start_reg;
        ev_next         = EV_NONE;
        if (hot && pump_reg)
        begin
            pump_next       = 1'b0;
            last_water_next = now_reg;
            ev_next         = EV_HEAT;
        end
        else if (soak_reg)
        begin
            if (time_ge_reg)
            begin
                soak_next = 1'b0;
                want_next = is_dry;
                ev_next   = EV_SOAK;
            end
        end
        else if (pump_reg)
        begin
            if (!want_pre || is_sat || time_ge_reg)
            begin
                pump_next       = 1'b0;
                last_water_next = now_reg;
                soak_next       = 1'b1;
                soak_start_next = now_reg;
                ev_next         = EV_STOP;
            end
        end
        else if (want_pre && is_dry && !hot && time_ge_reg)
        begin
            pump_next       = 1'b1;
            pump_start_next = now_reg;
            ev_next         = EV_START;
        end

        if (pump_next)
        begin
            mode_next = MODE_WATER;
        end
        else if (soak_next)
        begin
            mode_next = MODE_SOAK;
        end
        else
        begin
            mode_next = MODE_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pump_reg       <= 1'b0;
            want_reg       <= 1'b0;
            soak_reg       <= 1'b0;
            last_water_reg <= '0;
            pump_start_reg <= '0;
            soak_start_reg <= '0;
        end
        else if (cmd.eval)
        begin
            pump_reg       <= pump_next;
            want_reg       <= want_next;
            soak_reg       <= soak_next;
            last_water_reg <= last_water_next;
            pump_start_reg <= pump_start_next;
            soak_start_reg <= soak_start_next;
        end
    end

    // Hold the result beat
    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            pct_out_reg  <= pct;
            hot_out_reg  <= hot;
            mode_out_reg <= mode_next;
            ev_out_reg   <= ev_next;
        end
    end

    assign moisture_percent = pct_out_reg;
    assign temp_high        = hot_out_reg;
    assign wants_water      = want_reg;
    assign pump_on          = pump_reg;
    assign mode             = mode_out_reg;
    assign event_res        = ev_out_reg;

endmodule

`default_nettype wire

[design/irrigation_pump_controller_core.sv]
// Irrigation pump controller core.
// in_ch carries one sample per beat: raw moisture reading, temperature in
// tenths of a degree with its valid flag, and a wrapping millisecond time.
// out_ch returns exactly one result beat per sample: moisture percent, heat
// flag, want-water flag, pump drive, pump mode and an event code.
// cfg_ch writes one register per beat (index 0..7); it is always ready and
// is meant to be used only while no sample is in flight.
// A sample is captured, prepared, divided by the restoring divider, which
// resolves one percent bit per cycle, and evaluated into the output
// register; no new sample is taken until the evaluate step is done.
// The result sits in an output register; while the receiver stalls it holds,
// and one more sample can be taken and worked up to the evaluate step,
// where it waits until the held beat is taken.
// Reset clears the pump state, timestamps and the result valid flag, and
// loads the default calibration and thresholds.
`default_nettype none

module irrigation_pump_controller_core #(
    parameter int TIME_BITS   = ipc_pkg::TIME_BITS_DEF,
    parameter int SENSOR_BITS = ipc_pkg::SENSOR_BITS_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    ipc_sample_if.sink     in_ch,
    ipc_result_if.source   out_ch,
    ipc_cfg_if.sink        cfg_ch
);
    import ipc_pkg::*;

    ipc_cmd_t cmd;

    assign cfg_ch.ready = 1'b1;

    ipc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    ipc_datapath #(
        .TIME_BITS   (TIME_BITS),
        .SENSOR_BITS (SENSOR_BITS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .cfg_write          (cfg_ch.valid),
        .cfg_index          (cfg_ch.index),
        .cfg_data           (cfg_ch.data),
        .raw_moisture       (in_ch.raw_moisture),
        .temperature_tenths (in_ch.temperature_tenths),
        .temp_valid         (in_ch.temp_valid),
        .now_ms             (in_ch.now_ms),
        .moisture_percent   (out_ch.moisture_percent),
        .temp_high          (out_ch.temp_high),
        .wants_water        (out_ch.wants_water),
        .pump_on            (out_ch.pump_on),
        .mode               (out_ch.mode),
        .event_res          (out_ch.event_res)
    );

endmodule

`default_nettype wire

[design/ipc_checker.sv]
`default_nettype none

module ipc_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic                         temp_high,
    input wire logic                         pump_on,
    input wire logic [ipc_pkg::MODE_W-1:0]   mode,
    input wire logic [ipc_pkg::EV_W-1:0]     event_res
);
    import ipc_pkg::*;

    // Pump drive and watering mode agree
    a_pump_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pump_on == (mode == MODE_WATER)))
        else $error("pump drive and mode disagree");

    // A start leaves the pump running
    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == EV_START) |-> pump_on)
        else $error("start event without pump running");

    // A normal stop enters soak
    a_stop_soaks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == EV_STOP) |-> (!pump_on && mode == MODE_SOAK))
        else $error("normal stop did not enter soak");

    // A heat stop needs heat and leaves the pump idle
    a_heat_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == EV_HEAT) |-> (temp_high && mode == MODE_IDLE))
        else $error("heat stop without heat or not idle");

    // A stalled result beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result beat dropped while stalled");

endmodule

bind irrigation_pump_controller_core ipc_checker u_ipc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .temp_high (out_ch.temp_high),
    .pump_on   (out_ch.pump_on),
    .mode      (out_ch.mode),
    .event_res (out_ch.event_res)
);

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import ipc_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int WATCHDOG_MAX  = 5000;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 42;
    localparam int FLOOD_ITEMS   = 12;
    localparam int TEMP_MIN      = -400;
    localparam int TEMP_MAX      = 800;
    localparam int RAW_MAX       = 1023;

    // Index past the register map; the core must drop writes to it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd8;

    typedef struct {
        logic [SENSOR_BITS_DEF-1:0] raw;
        logic signed [TEMP_W-1:0]   temp;
        logic                       tvalid;
        logic [TIME_BITS_DEF-1:0]   now;
    } sample_t;

    typedef struct {
        logic [PCT_W-1:0]  moisture_pct;
        logic              heat;
        logic              want;
        logic              pump;
        logic [MODE_W-1:0] mode;
        logic [EV_W-1:0]   ev_code;
    } status_t;

    logic clk;
    logic rst_n;

    ipc_sample_if in_if ();
    ipc_result_if res_if ();
    ipc_cfg_if    cfg_if ();

    irrigation_pump_controller_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .out_ch (res_if),
        .cfg_ch (cfg_if)
    );

    // Controller settings as seen by the predictor
    logic [PCT_W-1:0]        dry_pct_th;
    logic [PCT_W-1:0]        sat_pct_th;
    logic [MAX_PUMP_W-1:0]   pump_limit_ms;
    logic [LONG_MS_W-1:0]    gap_ms;
    logic [LONG_MS_W-1:0]    soak_len_ms;
    logic signed [TEMP_W-1:0] heat_limit;
    logic [SENSOR_CFG_W-1:0] cal_dry;
    logic [SENSOR_CFG_W-1:0] cal_wet;

    // Pump state as seen by the predictor
    logic                     pump_running;
    logic                     want_water;
    logic                     soak_active;
    logic [TIME_BITS_DEF-1:0] last_water_ms;
    logic [TIME_BITS_DEF-1:0] pump_start_ms;
    logic [TIME_BITS_DEF-1:0] soak_start_ms;

    status_t status_q[$];
    int      mismatch_count;
    int      idle_cycles;
    bit      steady_flow;
    bit      hold_req;
    bit      offering;

    // Plant model driving the well-formed stimulus
    int                       soil_raw;
    logic [TIME_BITS_DEF-1:0] plant_ms;
    int                       step_max_ms;

    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    function automatic logic [PCT_W-1:0] moisture_of(input logic [SENSOR_BITS_DEF-1:0] raw);
        int span;
        int q;
        span = int'(cal_wet) - int'(cal_dry);
        if (span == 0)
            return '0;
        q = ((int'(raw) - int'(cal_dry)) * int'(PCT_FULL)) / span;
        if (q < 0)
            q = 0;
        if (q > int'(PCT_FULL))
            q = int'(PCT_FULL);
        return q[PCT_W-1:0];
    endfunction

    // Advance the pump state machine by one sample and return its status
    function automatic status_t irrigate_step(input sample_t s);
        status_t          st;
        logic [PCT_W-1:0] pct;
        logic             hot;
        pct = moisture_of(s.raw);
        hot = s.tvalid && (s.temp > heat_limit);
        st.ev_code = EV_NONE;

        if (pct <= dry_pct_th)
            want_water = 1'b1;
        else if (pct >= sat_pct_th)
            want_water = 1'b0;

        if (hot && pump_running)
        begin
            pump_running  = 1'b0;
            last_water_ms = s.now;
            st.ev_code    = EV_HEAT;
        end
        else if (soak_active)
        begin
            if (TIME_BITS_DEF'(s.now - soak_start_ms) >= soak_len_ms)
            begin
                soak_active = 1'b0;
                want_water  = (pct <= dry_pct_th);
                st.ev_code  = EV_SOAK;
            end
        end
        else if (pump_running)
        begin
            if (!want_water || pct >= sat_pct_th ||
                TIME_BITS_DEF'(s.now - pump_start_ms) >= pump_limit_ms)
            begin
                pump_running  = 1'b0;
                last_water_ms = s.now;
                soak_active   = 1'b1;
                soak_start_ms = s.now;
                st.ev_code    = EV_STOP;
            end
        end
        else if (want_water && pct <= dry_pct_th && !hot)
        begin
            if (TIME_BITS_DEF'(s.now - last_water_ms) >= gap_ms)
            begin
                pump_running  = 1'b1;
                pump_start_ms = s.now;
                st.ev_code    = EV_START;
            end
        end

        st.moisture_pct = pct;
        st.heat         = hot;
        st.want         = want_water;
        st.pump         = pump_running;
        st.mode         = pump_running ? MODE_WATER : (soak_active ? MODE_SOAK : MODE_IDLE);
        return st;
    endfunction

    task automatic apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_DRY_TH:   dry_pct_th    = value[PCT_W-1:0];
            REG_SAT_TH:   sat_pct_th    = value[PCT_W-1:0];
            REG_MAX_PUMP: pump_limit_ms = value[MAX_PUMP_W-1:0];
            REG_MIN_GAP:  gap_ms        = value[LONG_MS_W-1:0];
            REG_SOAK:     soak_len_ms   = value[LONG_MS_W-1:0];
            REG_TEMP_LIM: heat_limit    = value[TEMP_W-1:0];
            REG_SENS_DRY: cal_dry       = value[SENSOR_CFG_W-1:0];
            REG_SENS_WET: cal_wet       = value[SENSOR_CFG_W-1:0];
            default: ;
        endcase
    endtask

    function automatic int idle_span();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Fill the bits above a register's width with noise
    function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
                                                        input int w);
        logic [CFG_DATA_W-1:0] mask;
        mask = (CFG_DATA_W'(1) << w) - 1;
        return (CFG_DATA_W'($urandom) & ~mask) | (v & mask);
    endfunction

    function automatic sample_t make_sample(input int raw, input int temp, input bit tv,
                                            input logic [TIME_BITS_DEF-1:0] now);
        sample_t s;
        s.raw    = raw[SENSOR_BITS_DEF-1:0];
        s.temp   = temp[TEMP_W-1:0];
        s.tvalid = tv;
        s.now    = now;
        return s;
    endfunction

    // Offer one sample, hold it until taken, then idle for a random gap
    task automatic send_sample(input sample_t s);
        int gap;
        in_if.valid              <= 1'b1;
        in_if.raw_moisture       <= s.raw;
        in_if.temperature_tenths <= s.temp;
        in_if.temp_valid         <= s.tvalid;
        in_if.now_ms             <= s.now;
        offering = 1'b1;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        status_q.push_back(irrigate_step(s));
        gap = idle_span();
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and hold until every status beat is back
    task automatic wait_drained();
        if (offering)
        begin
            in_if.valid <= 1'b0;
            offering = 1'b0;
        end
        while (status_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        apply_setting(idx, value);
    endtask

    task automatic load_settings(input int dth, input int sth, input int pump_ms,
                                 input int min_gap, input int soak, input int heat,
                                 input int dry_raw, input int wet_raw);
        wait_drained();
        write_reg(REG_DRY_TH,   with_junk(dth, PCT_W));
        write_reg(REG_SAT_TH,   with_junk(sth, PCT_W));
        write_reg(REG_MAX_PUMP, with_junk(pump_ms, MAX_PUMP_W));
        write_reg(REG_MIN_GAP,  with_junk(min_gap, LONG_MS_W));
        write_reg(REG_SOAK,     with_junk(soak, LONG_MS_W));
        write_reg(REG_TEMP_LIM, with_junk(heat, TEMP_W));
        write_reg(REG_SENS_DRY, with_junk(dry_raw, SENSOR_CFG_W));
        write_reg(REG_SENS_WET, with_junk(wet_raw, SENSOR_CFG_W));
        cfg_if.valid <= 1'b0;
    endtask

    // Next sample: mostly a plant that dries out and wets while pumping
    function automatic sample_t next_plant_sample();
        int target;
        int drift;
        int temp;
        bit tv;
        if ($urandom_range(0, 99) >= 88)
            return make_sample($urandom_range(0, RAW_MAX),
                               $urandom_range(0, TEMP_MAX - TEMP_MIN) + TEMP_MIN,
                               $urandom_range(0, 1), $urandom);
        target = pump_running ? int'(cal_wet) : int'(cal_dry);
        drift  = $urandom_range(0, 40);
        if ($urandom_range(0, 99) < 5)
            soil_raw = $urandom_range(0, RAW_MAX);
        else if (soil_raw < target)
            soil_raw = (soil_raw + drift > target) ? target : soil_raw + drift;
        else
            soil_raw = (soil_raw - drift < target) ? target : soil_raw - drift;
        plant_ms = plant_ms + TIME_BITS_DEF'($urandom_range(0, step_max_ms));
        if ($urandom_range(0, 99) < 12)
            temp = int'(heat_limit) + $urandom_range(1, 100);
        else
            temp = int'(heat_limit) - $urandom_range(0, 300);
        if (temp > TEMP_MAX)
            temp = TEMP_MAX;
        if (temp < TEMP_MIN)
            temp = TEMP_MIN;
        tv = ($urandom_range(0, 99) < 92);
        return make_sample(soil_raw, temp, tv, plant_ms);
    endfunction

    task automatic report_status(input string what, input status_t exp_s, input status_t got);
        if (mismatch_count < MAX_REPORTS)
            $display({"%0t status error (%s): ",
                      "exp pct=%0d heat=%0b want=%0b pump=%0b mode=%0d ev=%0d, ",
                      "got pct=%0d heat=%0b want=%0b pump=%0b mode=%0d ev=%0d"},
                     $realtime, what, exp_s.moisture_pct, exp_s.heat, exp_s.want, exp_s.pump,
                     exp_s.mode, exp_s.ev_code, got.moisture_pct, got.heat, got.want,
                     got.pump, got.mode, got.ev_code);
        mismatch_count++;
    endtask

    task automatic check_status();
        status_t got;
        status_t exp_s;
        got.moisture_pct = res_if.moisture_percent;
        got.heat         = res_if.temp_high;
        got.want         = res_if.wants_water;
        got.pump         = res_if.pump_on;
        got.mode         = res_if.mode;
        got.ev_code      = res_if.event_res;
        if (status_q.size() == 0)
        begin
            exp_s = '{default: '0};
            report_status("unexpected beat", exp_s, got);
        end
        else
        begin
            exp_s = status_q.pop_front();
            if (got.moisture_pct !== exp_s.moisture_pct || got.heat !== exp_s.heat ||
                got.want !== exp_s.want || got.pump !== exp_s.pump ||
                got.mode !== exp_s.mode || got.ev_code !== exp_s.ev_code)
                report_status("field differs", exp_s, got);
        end
    endtask

    // Check each status beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            check_status();
    end

    // Abort when no beat moves on any channel for too long
    always @(posedge clk)
    begin
        if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: random stalls, steady stretches and one long hold on request
    initial
    begin
        int  span;
        logic lvl;
        res_if.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                lvl      = 1'b0;
                span     = LONG_HOLD;
                hold_req = 1'b0;
            end
            else if (steady_flow)
            begin
                lvl  = 1'b1;
                span = 1;
            end
            else if ($urandom_range(0, 99) < 65)
            begin
                lvl  = 1'b1;
                span = $urandom_range(1, 8);
            end
            else
            begin
                lvl  = 1'b0;
                span = idle_span() + 1;
            end
            res_if.ready <= lvl;
            repeat (span) @(posedge clk);
        end
    end

    // Power-up gap, first start, heat stop, time stop, soak end and restart
    task automatic test_power_up_defaults();
        send_sample(make_sample(RAW_MAX, 200, 1'b1, 32'd5000));
        send_sample(make_sample(RAW_MAX, TEMP_MAX, 1'b0, 32'd10000));
        send_sample(make_sample(RAW_MAX, TEMP_MIN, 1'b1, 32'd10100));
        send_sample(make_sample(RAW_MAX, 301, 1'b1, 32'd10200));
        send_sample(make_sample(RAW_MAX, 300, 1'b1, 32'd10300));
        send_sample(make_sample(RAW_MAX, 0, 1'b1, 32'd20200));
        send_sample(make_sample(RAW_MAX, 0, 1'b1, 32'd20700));
        send_sample(make_sample(0, 0, 1'b1, 32'd25000));
        send_sample(make_sample(RAW_MAX, 0, 1'b1, 32'd35700));
        send_sample(make_sample(RAW_MAX, 0, 1'b1, 32'd35701));
        send_sample(make_sample(0, 0, 1'b1, 32'd35800));
    endtask

    // Equal calibrations, a rising map, and a write to an unknown index
    task automatic test_calibration();
        wait_drained();
        write_reg(REG_UNUSED, $urandom);
        load_settings(30, 45, 500, 10000, 15000, 300, 512, 512);
        send_sample(make_sample(0, 0, 1'b1, 32'd100000));
        send_sample(make_sample(RAW_MAX, 0, 1'b1, 32'd100001));
        load_settings(30, 45, 500, 10000, 15000, 300, 0, RAW_MAX);
        send_sample(make_sample(0, 0, 1'b1, 32'd200000));
        send_sample(make_sample(RAW_MAX, 0, 1'b1, 32'd200100));
        send_sample(make_sample(511, 0, 1'b1, 32'd200200));
    endtask

    // Inverted thresholds and the temperature limit at both ends
    task automatic test_thresholds_and_heat();
        load_settings(60, 40, 1000, 0, 0, 300, RAW_MAX, 300);
        send_sample(make_sample(661, 0, 1'b1, 32'hFFFF_FFF0));
        send_sample(make_sample(661, 0, 1'b1, 32'hFFFF_FFF8));
        send_sample(make_sample(661, 0, 1'b1, 32'h0000_0004));
        send_sample(make_sample(661, 0, 1'b1, 32'h0000_0010));
        load_settings(60, 40, 1000, 0, 0, TEMP_MIN, RAW_MAX, 300);
        send_sample(make_sample(RAW_MAX, TEMP_MIN + 1, 1'b1, 32'd50));
        send_sample(make_sample(RAW_MAX, TEMP_MIN, 1'b1, 32'd60));
        send_sample(make_sample(RAW_MAX, TEMP_MIN + 1, 1'b1, 32'd70));
        load_settings(60, 40, 1000, 0, 0, TEMP_MAX, RAW_MAX, 300);
        send_sample(make_sample(RAW_MAX, TEMP_MAX, 1'b1, 32'd80));
        send_sample(make_sample(RAW_MAX, TEMP_MAX, 1'b1, 32'd90));
    endtask

    // Hold the result side long enough for the core to stall its input
    task automatic test_output_backpressure();
        load_settings(30, 45, 200, 100, 300, 300, RAW_MAX, 300);
        soil_raw    = RAW_MAX;
        plant_ms    = 32'd1000;
        step_max_ms = 60;
        hold_req    = 1'b1;
        while (hold_req)
            @(posedge clk);
        steady_flow = 1'b1;
        repeat (FLOOD_ITEMS) send_sample(next_plant_sample());
        steady_flow = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_phases();
        int dth;
        int sth;
        int r;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
            begin
                load_settings(100, 100, 16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF, TEMP_MAX,
                              RAW_MAX, 0);
                step_max_ms = 3_000_000;
            end
            else if (p == 1)
            begin
                load_settings(0, 0, 0, 0, 0, TEMP_MIN, 0, 0);
                step_max_ms = 20;
            end
            else
            begin
                dth = $urandom_range(0, 100);
                sth = dth + $urandom_range(0, 40);
                if (sth > 100 || $urandom_range(0, 99) < 25)
                    sth = $urandom_range(0, 100);
                r = $urandom_range(0, 99);
                if (r < 70)
                    load_settings(dth, sth, $urandom_range(0, 400), $urandom_range(0, 600),
                                  $urandom_range(0, 800), $urandom_range(150, 450) - 0,
                                  $urandom_range(700, RAW_MAX), $urandom_range(0, 400));
                else if (r < 85)
                    load_settings(dth, sth, $urandom_range(0, 400), $urandom_range(0, 600),
                                  $urandom_range(0, 800),
                                  $urandom_range(0, TEMP_MAX - TEMP_MIN) + TEMP_MIN,
                                  $urandom_range(0, 400), $urandom_range(700, RAW_MAX));
                else
                    load_settings(dth, sth, $urandom_range(0, 400), $urandom_range(0, 600),
                                  $urandom_range(0, 800), $urandom_range(150, 450),
                                  $urandom_range(0, RAW_MAX), $urandom_range(0, RAW_MAX));
                step_max_ms = $urandom_range(5, 150);
            end
            steady_flow = (p % 4 == 2);
            soil_raw    = $urandom_range(0, RAW_MAX);
            if ($urandom_range(0, 1) == 1)
                plant_ms = 32'hFFFF_FFFF - TIME_BITS_DEF'($urandom_range(0, 5000));
            else
                plant_ms = $urandom;
            repeat (PHASE_ITEMS) send_sample(next_plant_sample());
            steady_flow = 1'b0;
        end
    endtask

    initial
    begin
        rst_n                    = 1'b0;
        in_if.valid              = 1'b0;
        in_if.raw_moisture       = '0;
        in_if.temperature_tenths = '0;
        in_if.temp_valid         = 1'b0;
        in_if.now_ms             = '0;
        cfg_if.valid             = 1'b0;
        cfg_if.index             = '0;
        cfg_if.data              = '0;
        mismatch_count           = 0;
        idle_cycles              = 0;
        steady_flow              = 1'b0;
        hold_req                 = 1'b0;
        offering                 = 1'b0;
        soil_raw                 = RAW_MAX;
        plant_ms                 = '0;
        step_max_ms              = 100;
        dry_pct_th               = DRY_TH_RST;
        sat_pct_th               = SAT_TH_RST;
        pump_limit_ms            = MAX_PUMP_RST;
        gap_ms                   = MIN_GAP_RST;
        soak_len_ms              = SOAK_RST;
        heat_limit               = TEMP_LIM_RST;
        cal_dry                  = SENS_DRY_RST;
        cal_wet                  = SENS_WET_RST;
        pump_running             = 1'b0;
        want_water               = 1'b0;
        soak_active              = 1'b0;
        last_water_ms            = '0;
        pump_start_ms            = '0;
        soak_start_ms            = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_power_up_defaults();
        test_calibration();
        test_thresholds_and_heat();
        test_output_backpressure();
        test_random_phases();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
design/ipc_pkg.sv
design/ipc_sample_if.sv
design/ipc_result_if.sv
design/ipc_cfg_if.sv
design/ipc_ctrl.sv
design/ipc_datapath.sv
design/irrigation_pump_controller_core.sv
design/ipc_checker.sv
verif/tb_top.sv
